### hdl/rsg_pkg.sv
`default_nettype none

package rsg_pkg;

	localparam int PAIR_W  = 6;
	localparam int HP_W    = 7;
	localparam int RATIO_W = 32;
	localparam int FREQ_W  = 33;
	localparam int ROT_W   = 33;
	localparam int CFG_W   = 32;

	// angle constants in Q.32 radians
	localparam logic [34:0] TWO_PI_Q32  = 35'd26986075409;
	localparam logic [34:0] PI_Q32      = 35'd13493037705;
	localparam logic [34:0] HALF_PI_Q32 = 35'd6746518852;
	// two pi minus half pi, upper edge of the fold-by-pi range
	localparam logic [34:0] FOLD_HI_Q32 = 35'd20239556557;

	localparam logic signed [ROT_W-1:0] GAIN_Q30 = 33'sd652032874;

	// atan(2^-i) in Q2.30, rounded
	localparam int ATAN_N = 24;
	localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
		32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
		32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
		32'd262144,    32'd131072,    32'd65536,     32'd32768,
		32'd16384,     32'd8192,      32'd4096,      32'd2048,
		32'd1024,      32'd512,       32'd256,       32'd128
	};

	// register index codes
	localparam logic REG_HALF_PAIRS = 1'b0;
	localparam logic REG_FREQ_RATIO = 1'b1;

	localparam logic [HP_W-1:0]    HALF_PAIRS_RST = 7'd32;
	localparam logic [RATIO_W-1:0] FREQ_RATIO_RST = 32'd3435973837;

	typedef struct packed {
		logic load;
		logic ang_mul;
		logic mod_step;
		logic fold;
		logic rot_step;
		logic freq_mul;
		logic freq_rnd;
		logic finish;
		logic last;
	} rsg_cmd_t;

	typedef struct packed {
		logic out_full;
	} rsg_sts_t;

endpackage

`default_nettype wire

### hdl/rsg_lane.sv
`default_nettype none

module rsg_lane
	import rsg_pkg::*;
#(
	parameter int POS_BITS     = 10,
	parameter int OUT_BITS     = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                                clk,
	input  wire rsg_cmd_t                            cmd,
	input  wire logic [$clog2(POS_BITS-1)-1:0]       mod_idx,
	input  wire logic [$clog2(CORDIC_STEPS)-1:0]     rot_idx,
	input  wire logic [POS_BITS-1:0]                 pos,
	input  wire logic [FREQ_W-1:0]                   freq,
	output logic      [OUT_BITS-1:0]                 cos_val,
	output logic      [OUT_BITS-1:0]                 sin_val
);

	localparam int AW = POS_BITS + FREQ_W;
	localparam int SH = 30 - (OUT_BITS - 1);
	localparam logic signed [33:0] RND = 34'sd1 <<< (SH - 1);
	localparam logic signed [33:0] LIM = (34'sd1 <<< (OUT_BITS - 1)) - 34'sd1;

	logic        [AW-1:0]    ang_q;
	logic        [AW-1:0]    mod_sub;
	logic        [34:0]      a_r;
	logic signed [36:0]      a_f;
	logic signed [36:0]      z_wide;
	logic                    neg_d;
	logic signed [ROT_W-1:0] x_q, y_q, z_q;
	logic                    neg_q;
	logic signed [ROT_W-1:0] dx, dy, atan_v;

	function automatic logic [OUT_BITS-1:0] to_out(input logic signed [ROT_W-1:0] v,
		input logic ng);
		logic signed [33:0] w;
		logic signed [33:0] r;
		w = ng ? -34'(v) : 34'(v);
		r = (w + RND) >>> SH;
		if (r > LIM) begin
			r = LIM;
		end else if (r < -LIM) begin
			r = -LIM;
		end
		return r[OUT_BITS-1:0];
	endfunction

	// restoring reduction, one multiple of two pi per step
	assign mod_sub = AW'(TWO_PI_Q32) << mod_idx;

	always_ff @(posedge clk) begin
		if (cmd.ang_mul) begin
			ang_q <= AW'(pos) * AW'(freq);
		end else if (cmd.mod_step && (ang_q >= mod_sub)) begin
			ang_q <= ang_q - mod_sub;
		end
	end

	// fold [0, 2pi) into [-pi/2, pi/2]
	assign a_r = ang_q[34:0];

	always_comb begin
		if (a_r <= HALF_PI_Q32) begin
			a_f   = $signed({2'b00, a_r});
			neg_d = 1'b0;
		end else if (a_r < FOLD_HI_Q32) begin
			a_f   = $signed({2'b00, a_r}) - $signed({2'b00, PI_Q32});
			neg_d = 1'b1;
		end else begin
			a_f   = $signed({2'b00, a_r}) - $signed({2'b00, TWO_PI_Q32});
			neg_d = 1'b0;
		end
	end

	assign z_wide = (a_f + 37'sd2) >>> 2;

	assign dx     = y_q >>> rot_idx;
	assign dy     = x_q >>> rot_idx;
	assign atan_v = $signed({1'b0, ATAN_Q30[rot_idx]});

	always_ff @(posedge clk) begin
		if (cmd.fold) begin
			x_q   <= GAIN_Q30;
			y_q   <= '0;
			z_q   <= $signed(z_wide[ROT_W-1:0]);
			neg_q <= neg_d;
		end else if (cmd.rot_step) begin
			if (!z_q[ROT_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_v;
			end
		end
	end

	assign cos_val = to_out(x_q, neg_q);
	assign sin_val = to_out(y_q, neg_q);

endmodule

`default_nettype wire

### hdl/rsg_dpath.sv
`default_nettype none

module rsg_dpath
	import rsg_pkg::*;
#(
	parameter int POS_BITS     = 10,
	parameter int OUT_BITS     = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire rsg_cmd_t                                    cmd,
	output rsg_sts_t                                         sts,
	input  wire logic [$clog2(POS_BITS-1)-1:0]               mod_idx,
	input  wire logic [$clog2(CORDIC_STEPS)-1:0]             rot_idx,
	input  wire logic [PAIR_W-1:0]                           pair_idx,
	input  wire logic [POS_BITS-1:0]                         in_row,
	input  wire logic [POS_BITS-1:0]                         in_col,
	input  wire logic [RATIO_W-1:0]                          freq_ratio,
	output logic                                             m_tvalid,
	input  wire logic                                        m_tready,
	output logic [((PAIR_W+4*OUT_BITS+7)/8)*8-1:0]           m_tdata,
	output logic                                             m_tlast
);

	localparam int OUT_DW = ((PAIR_W + 4 * OUT_BITS + 7) / 8) * 8;

	logic [POS_BITS-1:0] row_q, col_q;
	logic [FREQ_W-1:0]   freq_q;
	logic [63:0]         prod_q;
	logic                one_q;
	logic [63:0]         prod_rnd;
	logic [OUT_BITS-1:0] cos_row, sin_row, cos_col, sin_col;
	logic [OUT_DW-1:0]   data_q;
	logic                last_q;
	logic                full_q;

	assign prod_rnd = prod_q + 64'h0000_0000_8000_0000;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q <= in_row;
			col_q <= in_col;
		end
		if (cmd.load) begin
			freq_q <= {1'b1, {RATIO_W{1'b0}}};
		end else if (cmd.freq_rnd) begin
			// from 1.0 the product rounds to the ratio itself
			freq_q <= one_q ? {1'b0, freq_ratio} : {1'b0, prod_rnd[63:32]};
		end
		if (cmd.freq_mul) begin
			prod_q <= 64'(freq_q[RATIO_W-1:0]) * 64'(freq_ratio);
			one_q  <= freq_q[FREQ_W-1];
		end
	end

	rsg_lane #(
		.POS_BITS     (POS_BITS),
		.OUT_BITS     (OUT_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_row (
		.clk     (clk),
		.cmd     (cmd),
		.mod_idx (mod_idx),
		.rot_idx (rot_idx),
		.pos     (row_q),
		.freq    (freq_q),
		.cos_val (cos_row),
		.sin_val (sin_row)
	);

	rsg_lane #(
		.POS_BITS     (POS_BITS),
		.OUT_BITS     (OUT_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_col (
		.clk     (clk),
		.cmd     (cmd),
		.mod_idx (mod_idx),
		.rot_idx (rot_idx),
		.pos     (col_q),
		.freq    (freq_q),
		.cos_val (cos_col),
		.sin_val (sin_col)
	);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			data_q <= OUT_DW'({sin_col, cos_col, sin_row, cos_row, pair_idx});
			last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (cmd.finish) begin
			full_q <= 1'b1;
		end else if (m_tready) begin
			full_q <= 1'b0;
		end
	end

	assign sts.out_full = full_q;
	assign m_tvalid     = full_q;
	assign m_tdata      = data_q;
	assign m_tlast      = last_q;

endmodule

`default_nettype wire

### hdl/rsg_ctrl.sv
`default_nettype none

module rsg_ctrl
	import rsg_pkg::*;
#(
	parameter int POS_BITS     = 10,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [HP_W-1:0]                     pairs,
	input  wire rsg_sts_t                            sts,
	input  wire logic                                m_tready,
	output rsg_cmd_t                                 cmd,
	output logic [$clog2(POS_BITS-1)-1:0]            mod_idx,
	output logic [$clog2(CORDIC_STEPS)-1:0]          rot_idx,
	output logic [PAIR_W-1:0]                        pair_idx
);

	localparam int MOD_IW = $clog2(POS_BITS - 1);
	localparam int ROT_IW = $clog2(CORDIC_STEPS);
	localparam logic [MOD_IW-1:0] MOD_LAST = MOD_IW'(POS_BITS - 2);
	localparam logic [ROT_IW-1:0] ROT_LAST = ROT_IW'(CORDIC_STEPS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ANG  = 3'd1;
	localparam logic [2:0] ST_MOD  = 3'd2;
	localparam logic [2:0] ST_FOLD = 3'd3;
	localparam logic [2:0] ST_ROT  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [MOD_IW-1:0] mod_q;
	logic [ROT_IW-1:0] rot_q;
	logic [PAIR_W-1:0] pair_q;
	logic              last_pair;
	logic              out_free;

	assign last_pair = (({1'b0, pair_q} + 7'd1) == pairs);
	assign out_free  = !sts.out_full || m_tready;

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_ANG;
				end
			end
			ST_ANG: begin
				cmd.ang_mul = 1'b1;
				state_d     = ST_MOD;
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (mod_q == '0) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = ST_ROT;
			end
			ST_ROT: begin
				// next frequency is worked out while the rotation runs
				cmd.rot_step = 1'b1;
				cmd.freq_mul = (rot_q == '0);
				cmd.freq_rnd = (rot_q == ROT_IW'(1));
				if (rot_q == ROT_LAST) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					cmd.last   = last_pair;
					state_d    = last_pair ? ST_IDLE : ST_ANG;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mod_q   <= '0;
			rot_q   <= '0;
			pair_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.ang_mul) begin
				mod_q <= MOD_LAST;
			end else if (cmd.mod_step) begin
				mod_q <= mod_q - MOD_IW'(1);
			end
			if (cmd.fold) begin
				rot_q <= '0;
			end else if (cmd.rot_step) begin
				rot_q <= rot_q + ROT_IW'(1);
			end
			if (cmd.load) begin
				pair_q <= '0;
			end else if (cmd.finish && !last_pair) begin
				pair_q <= pair_q + PAIR_W'(1);
			end
		end
	end

	assign mod_idx  = mod_q;
	assign rot_idx  = rot_q;
	assign pair_idx = pair_q;

endmodule

`default_nettype wire

### hdl/rope_2d_sincos_generator_unit.sv
// 2-D rotary position embedding sine/cosine source.
// input stream: one grid position per transfer (s_tvalid/s_tready/s_tdata).
// output stream: for each frequency index i = 0 .. half_pairs-1 one transfer
// carrying i and cos/sin of row*freq_i and col*freq_i; m_tlast marks the
// final index of the position. freq_0 is 1.0, each later one is the previous
// times freq_ratio (Q0.32).
// apb port: half_pairs at 0x0, freq_ratio at 0x4; write only while idle.
// each pair runs in order through one angle multiply, POS_BITS-1 steps of the
// modulo two pi reduction, one fold step, then CORDIC_STEPS iterations of the
// rotation unit (row and column run side by side), then the load of the
// output register.
// one position is worked at a time; s_tready is high while idle, and the
// next position is taken while the last result still waits in the output
// register. when the receiver stalls, the block holds before loading the
// output register and resumes as soon as it is taken.
// reset returns the controller to idle, empties the output register and sets
// half_pairs to 32 and freq_ratio to 3435973837.
`default_nettype none

module rope_2d_sincos_generator_unit
	import rsg_pkg::*;
#(
	parameter int MAX_PAIRS    = 64,
	parameter int POS_BITS     = 10,
	parameter int OUT_BITS     = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// grid_row, grid_col
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [((2*POS_BITS+7)/8)*8-1:0]       s_tdata,
	// pair_index, cos_row, sin_row, cos_col, sin_col
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic [((PAIR_W+4*OUT_BITS+7)/8)*8-1:0]     m_tdata,
	output logic                                       m_tlast,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [2:0]                            paddr,
	input  wire logic [CFG_W-1:0]                      pwdata,
	output logic [CFG_W-1:0]                           prdata,
	output logic                                       pready
);

	localparam logic [HP_W-1:0]     MAX_P   = HP_W'(MAX_PAIRS);
	localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

	logic [HP_W-1:0]    half_pairs_q;
	logic [RATIO_W-1:0] freq_ratio_q;
	logic [HP_W-1:0]    pairs_eff;
	logic               cfg_wr;
	rsg_cmd_t           cmd;
	rsg_sts_t           sts;
	logic [$clog2(POS_BITS-1)-1:0]   mod_idx;
	logic [$clog2(CORDIC_STEPS)-1:0] rot_idx;
	logic [PAIR_W-1:0]  pair_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_pairs_q <= HALF_PAIRS_RST;
			freq_ratio_q <= FREQ_RATIO_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_HALF_PAIRS: half_pairs_q <= pwdata[HP_W-1:0];
				REG_FREQ_RATIO: freq_ratio_q <= pwdata[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_HALF_PAIRS: prdata = CFG_W'(half_pairs_q);
			REG_FREQ_RATIO: prdata = freq_ratio_q;
			default:        prdata = '0;
		endcase
	end

	// zero pairs counts as one, above the limit saturates
	always_comb begin
		if (half_pairs_q == '0) begin
			pairs_eff = HP_W'(1);
		end else if (half_pairs_q > MAX_P) begin
			pairs_eff = MAX_P;
		end else begin
			pairs_eff = half_pairs_q;
		end
	end

	rsg_ctrl #(
		.POS_BITS     (POS_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.pairs    (pairs_eff),
		.sts      (sts),
		.m_tready (m_tready),
		.cmd      (cmd),
		.mod_idx  (mod_idx),
		.rot_idx  (rot_idx),
		.pair_idx (pair_idx)
	);

	rsg_dpath #(
		.POS_BITS     (POS_BITS),
		.OUT_BITS     (OUT_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.mod_idx    (mod_idx),
		.rot_idx    (rot_idx),
		.pair_idx   (pair_idx),
		.in_row     (s_tdata[POS_BITS-1:0]),
		.in_col     (s_tdata[2*POS_BITS-1:POS_BITS]),
		.freq_ratio (freq_ratio_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, m_tdata[PAIR_W-1:0]} < pairs_eff))
		else $error("pair index beyond pair count");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (({1'b0, m_tdata[PAIR_W-1:0]} + 7'd1) == pairs_eff))
		else $error("last flag on wrong pair");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while working");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[PAIR_W+OUT_BITS-1:PAIR_W] != OUT_MIN) &&
			(m_tdata[PAIR_W+2*OUT_BITS-1:PAIR_W+OUT_BITS] != OUT_MIN)))
		else $error("row result outside saturation range");

endmodule

`default_nettype wire
